/* rtl/core/fwdp_pkg.sv */
// ----------------------------------------------------------------------------
// fwdp_pkg
// Shared types, constants and helpers of the fixed-width dictionary packer.
// ----------------------------------------------------------------------------
`default_nettype none

package fwdp_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ACC_W       = 15;
  localparam int BYTE_W      = 8;
  localparam int WID_W       = 4;

  typedef enum logic [1:0] {
    OP_LEARN  = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // search result, one cycle pulse on done
  typedef struct packed {
    logic             done;
    logic             found;
    logic [IDX_W-1:0] index;
  } srch_res_t;

  // command to the bit packer
  typedef struct packed {
    logic              valid;
    logic              flush;
    logic [BYTE_W-1:0] code;
    logic [WID_W-1:0]  width;
  } pk_cmd_t;

  // smallest width w with 2^w >= count, clamped to 1..8
  function automatic logic [WID_W-1:0] width_for_count(input logic [CNT_W-1:0] count);
    logic [WID_W-1:0] w;
    w = WID_W'(1);
    for (int k = 1; k < 8; k++) begin
      if (int'(count) > (1 << k)) begin
        w = WID_W'(k + 1);
      end
    end
    return w;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/fwdp_if.sv */
// ----------------------------------------------------------------------------
// fwdp interfaces
// Valid/ready channels for input items and packed result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface fwdp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] symbol;

  modport source (output valid, output operation, output symbol, input ready);
  modport sink   (input valid, input operation, input symbol, output ready);
endinterface

interface fwdp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;
  logic       is_last;
  logic [3:0] code_width;

  modport source (output valid, output packed_byte, output is_last, output code_width,
                  input ready);
  modport sink   (input valid, input packed_byte, input is_last, input code_width,
                  output ready);
endinterface

`default_nettype wire

/* rtl/core/fwdp_search.sv */
// ----------------------------------------------------------------------------
// fwdp_search
// Symbol table memory with a sequential lookup, one entry compared per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fwdp_search (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [7:0]                 sym,
  input  wire logic [fwdp_pkg::CNT_W-1:0] count,
  input  wire logic                       we,
  input  wire logic [fwdp_pkg::IDX_W-1:0] waddr,
  input  wire logic [7:0]                 wdata,
  output fwdp_pkg::srch_res_t             res
);

  logic [7:0]                 mem [fwdp_pkg::TABLE_DEPTH];
  logic                       busy_r;
  logic [fwdp_pkg::CNT_W-1:0] addr_r;
  logic [7:0]                 sym_r;
  logic [7:0]                 rd_data_r;
  logic [fwdp_pkg::IDX_W-1:0] rd_idx_r;
  logic                       rd_vld_r;
  logic                       hit;
  logic                       miss;
  logic                       issue;

  assign hit   = busy_r && rd_vld_r && (rd_data_r == sym_r);
  assign miss  = busy_r && !rd_vld_r && (addr_r >= count);
  assign issue = busy_r && !hit && (addr_r < count);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (issue) begin
      rd_data_r <= mem[addr_r[fwdp_pkg::IDX_W-1:0]];
      rd_idx_r  <= addr_r[fwdp_pkg::IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      rd_vld_r <= 1'b0;
      addr_r   <= '0;
    end else if (start) begin
      busy_r   <= 1'b1;
      rd_vld_r <= 1'b0;
      addr_r   <= '0;
    end else if (hit || miss) begin
      busy_r   <= 1'b0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= issue;
      if (issue) begin
        addr_r <= addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sym_r <= sym;
    end
  end

  assign res.done  = hit || miss;
  assign res.found = hit;
  assign res.index = rd_idx_r;

  a_done_busy : assert property (@(posedge clk) disable iff (!rst_n)
    res.done |-> busy_r)
    else $error("search done without a lookup in progress");

  a_hit_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    (res.done && res.found) |-> (fwdp_pkg::CNT_W'(res.index) < count))
    else $error("search hit beyond the filled entries");

endmodule

`default_nettype wire

/* rtl/core/fwdp_packer.sv */
// ----------------------------------------------------------------------------
// fwdp_packer
// Bit accumulator that packs codes MSB-first into bytes, with output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fwdp_packer (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire fwdp_pkg::pk_cmd_t cmd,
  output logic                   slot_free,
  fwdp_out_if.source             out_ch
);

  logic [fwdp_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic [3:0]                  fill_r, fill_nxt;
  logic                        out_valid_r;
  logic [7:0]                  byte_r, byte_nxt;
  logic                        last_r;
  logic [fwdp_pkg::WID_W-1:0]  width_r;
  logic                        emit;
  logic [fwdp_pkg::ACC_W-1:0]  acc_sh;
  logic [7:0]                  code_m;
  logic [8:0]                  mask9;
  logic [3:0]                  fill_sum;
  logic [3:0]                  rem;

  assign slot_free = !out_valid_r || out_ch.ready;

  always_comb begin
    mask9    = (9'd1 << cmd.width) - 9'd1;
    code_m   = cmd.code & mask9[7:0];
    acc_sh   = (acc_r << cmd.width) | fwdp_pkg::ACC_W'(code_m);
    fill_sum = fill_r + cmd.width;
    rem      = fill_sum - 4'd8;
    acc_nxt  = acc_r;
    fill_nxt = fill_r;
    byte_nxt = 8'h00;
    emit     = 1'b0;
    if (cmd.valid) begin
      if (cmd.flush) begin
        if (fill_r != 4'd0) begin
          emit     = 1'b1;
          byte_nxt = acc_r[7:0] << (4'd8 - fill_r);
          acc_nxt  = '0;
          fill_nxt = 4'd0;
        end
      end else if (fill_sum >= 4'd8) begin
        emit     = 1'b1;
        byte_nxt = 8'(acc_sh >> rem);
        acc_nxt  = acc_sh & ((fwdp_pkg::ACC_W'(1) << rem) - fwdp_pkg::ACC_W'(1));
        fill_nxt = rem;
      end else begin
        acc_nxt  = acc_sh;
        fill_nxt = fill_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      fill_r      <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r  <= acc_nxt;
      fill_r <= fill_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      byte_r  <= byte_nxt;
      last_r  <= cmd.flush;
      width_r <= cmd.width;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.packed_byte = byte_r;
  assign out_ch.is_last     = last_r;
  assign out_ch.code_width  = width_r;

  a_fill_below_byte : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.valid |=> (fill_r < 4'd8))
    else $error("pending bit count reached a full byte");

endmodule

`default_nettype wire

/* rtl/core/fixed_width_dictionary_packer.sv */
// ----------------------------------------------------------------------------
// fixed_width_dictionary_packer
// Learns a byte dictionary and packs fixed-width table indexes into bytes.
// ----------------------------------------------------------------------------
// usage:
//   in_ch takes one beat per item: operation (learn, encode, flush, clear)
//   and symbol. out_ch gives one beat per completed byte: packed_byte (first
//   code bit in bit 7), is_last (zero-padded flush byte) and code_width.
//   in_ch.ready is high only while the sequencer is idle.
//   learn and encode walk the symbol table one entry per cycle through the
//   table memory read port, from index 0 up to the first hit or the entry
//   count. clear acts straight from idle; flush goes through the pack step.
//   the output register parts the two sides: a new item is taken while a
//   byte waits. an encode hit or a flush holds in its pack step until the
//   register is free, so a stalled receiver stalls the input after one
//   waiting beat.
//   reset clears entry count, pending bits and the output register. the
//   table memory itself is not cleared; entries are only read below the
//   entry count, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_width_dictionary_packer (
  input  wire logic   clk,
  input  wire logic   rst_n,
  fwdp_in_if.sink     in_ch,
  fwdp_out_if.source  out_ch
);

  // one-hot sequencer states
  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_PACK   = 3'b100
  } state_t;

  state_t                      state_r, state_nxt;
  fwdp_pkg::op_t               op_r;
  logic [7:0]                  sym_r;
  logic [fwdp_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [fwdp_pkg::IDX_W-1:0]  idx_r;
  logic                        in_fire;
  logic                        srch_start;
  logic                        tbl_we;
  logic                        slot_free;
  fwdp_pkg::srch_res_t         res;
  fwdp_pkg::pk_cmd_t           cmd;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // lookup starts in the cycle after the item beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srch_start <= 1'b0;
    end else begin
      srch_start <= in_fire && ((fwdp_pkg::op_t'(in_ch.operation) == fwdp_pkg::OP_LEARN) ||
                                (fwdp_pkg::op_t'(in_ch.operation) == fwdp_pkg::OP_ENCODE));
    end
  end

  // unseen byte goes in at the end of the table while there is room
  assign tbl_we = (state_r == S_SEARCH) && res.done && !res.found &&
                  (op_r == fwdp_pkg::OP_LEARN) &&
                  (count_r < fwdp_pkg::CNT_W'(fwdp_pkg::TABLE_DEPTH));

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (fwdp_pkg::op_t'(in_ch.operation))
            fwdp_pkg::OP_LEARN,
            fwdp_pkg::OP_ENCODE: state_nxt = S_SEARCH;
            fwdp_pkg::OP_FLUSH:  state_nxt = S_PACK;
            fwdp_pkg::OP_CLEAR:  count_nxt = '0;
            default:             state_nxt = S_IDLE;
          endcase
        end
      end
      S_SEARCH: begin
        if (res.done) begin
          if (tbl_we) begin
            count_nxt = count_r + 1'b1;
          end
          if (op_r == fwdp_pkg::OP_ENCODE && res.found) begin
            state_nxt = S_PACK;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_PACK: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= fwdp_pkg::op_t'(in_ch.operation);
      sym_r <= in_ch.symbol;
    end
    if (state_r == S_SEARCH && res.done) begin
      idx_r <= res.index;
    end
  end

  fwdp_search u_search (
    .clk   (clk),
    .rst_n (rst_n),
    .start (srch_start),
    .sym   (sym_r),
    .count (count_r),
    .we    (tbl_we),
    .waddr (count_r[fwdp_pkg::IDX_W-1:0]),
    .wdata (sym_r),
    .res   (res)
  );

  // pack step: one command per encode hit or flush
  always_comb begin
    cmd.valid = (state_r == S_PACK) && slot_free;
    cmd.flush = (op_r == fwdp_pkg::OP_FLUSH);
    cmd.code  = 8'(idx_r);
    cmd.width = fwdp_pkg::width_for_count(count_r);
  end

  fwdp_packer u_packer (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .slot_free (slot_free),
    .out_ch    (out_ch)
  );

  a_learn_grows : assert property (@(posedge clk) disable iff (!rst_n)
    tbl_we |=> (count_r == $past(count_r) + 1'b1))
    else $error("learned byte did not extend the table");

  a_pack_from_op : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PACK) |-> (op_r == fwdp_pkg::OP_ENCODE || op_r == fwdp_pkg::OP_FLUSH))
    else $error("pack step entered for an item without codes");

endmodule

`default_nettype wire

/* tb/fixed_width_dictionary_packer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_width_dictionary_packer_tb
// Self-checking bench for the dictionary code packer: drives learn, encode,
// flush and clear beats, predicts every packed byte from a local dictionary
// and bit accumulator, and checks each output beat in order under random
// idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------

module fixed_width_dictionary_packer_tb;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 11;
  // worst search plus an idle gap on each side plus the long hold-off;
  // the limit leaves several times that margin
  localparam int STALL_LIMIT   = 5000;
  localparam int DRAIN_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 270;
  localparam int HOLD_OFF      = 400;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       is_last;
    logic [3:0] code_width;
  } packed_beat_t;

  logic clk;
  logic rst_n;

  fwdp_in_if  in_ch ();
  fwdp_out_if out_ch ();

  fixed_width_dictionary_packer i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predictor copy of the dictionary and the pending bit stream
  logic [7:0]   dict [fwdp_pkg::TABLE_DEPTH];
  logic [8:0]   dict_count;
  logic [14:0]  pend_bits;
  logic [3:0]   pend_fill;

  packed_beat_t predicted_beats [$];
  packed_beat_t oldest_beat;

  int fail_count;
  int beats_checked;
  int items_sent;
  int big_tables;
  int quiet_cycles;
  int op_seen [4];
  bit idle_on;
  int hold_cycles;

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // code width for a dictionary size: smallest k with 2^k covering it, 1..8
  function automatic logic [3:0] code_bits(input logic [8:0] cnt);
    logic [3:0] w;
    w = 4'd8;
    for (int k = 8; k >= 1; k--) begin
      if (int'(cnt) <= (1 << k)) w = 4'(k);
    end
    return w;
  endfunction

  // linear search over the live entries only
  function automatic bit dict_lookup(input logic [7:0] sym, output logic [7:0] pos);
    pos = '0;
    for (int i = 0; i < int'(dict_count); i++) begin
      if (dict[8'(i)] == sym) begin
        pos = 8'(i);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // applies one item to the predictor; returns 1 when a packed byte comes out
  function automatic bit pack_step(input fwdp_pkg::op_t op, input logic [7:0] sym,
                                   output packed_beat_t beat);
    logic [7:0]  pos;
    logic [3:0]  w;
    logic [14:0] code;
    beat = '0;
    w = code_bits(dict_count);
    case (op)
      fwdp_pkg::OP_LEARN: begin
        // known byte or full table: nothing happens
        if (!dict_lookup(sym, pos) && int'(dict_count) < fwdp_pkg::TABLE_DEPTH) begin
          dict[dict_count[7:0]] = sym;
          dict_count++;
        end
        return 1'b0;
      end
      fwdp_pkg::OP_CLEAR: begin
        // pending bits survive a clear
        dict_count = '0;
        return 1'b0;
      end
      fwdp_pkg::OP_FLUSH: begin
        if (pend_fill == 0) return 1'b0;
        beat.packed_byte = 8'(pend_bits << (8 - pend_fill));
        beat.is_last     = 1'b1;
        beat.code_width  = w;
        pend_bits = '0;
        pend_fill = '0;
        return 1'b1;
      end
      default: begin
        // unknown byte, empty table included: no bits
        if (!dict_lookup(sym, pos)) return 1'b0;
        code = 15'(pos) & ((15'd1 << w) - 15'd1);
        pend_bits = (pend_bits << w) | code;
        pend_fill = pend_fill + w;
        if (pend_fill < 8) return 1'b0;
        pend_fill = pend_fill - 4'd8;
        beat.packed_byte = 8'(pend_bits >> pend_fill);
        beat.is_last     = 1'b0;
        beat.code_width  = w;
        pend_bits = pend_bits & ((15'd1 << pend_fill) - 15'd1);
        return 1'b1;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // input side: one beat per call, optional idle burst in front
  // ---------------------------------------------------------------------------
  task automatic send_item(input fwdp_pkg::op_t op, input logic [7:0] sym);
    packed_beat_t beat;
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.symbol    <= sym;
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
    // accepted at this edge: predict before any result can show up
    if (pack_step(op, sym, beat)) predicted_beats.push_back(beat);
    items_sent++;
    op_seen[op]++;
  endtask

  // ---------------------------------------------------------------------------
  // output side: receiver idling and the long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        // long stretch so the block fills up and stalls its input
        out_ch.ready <= 1'b0;
        repeat (hold_cycles - 1) @(negedge clk);
        hold_cycles = 0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17) - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // result check: every output beat against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (predicted_beats.size() == 0) begin
        $error("unexpected beat: packed_byte %02h is_last %0d code_width %0d",
               out_ch.packed_byte, out_ch.is_last, out_ch.code_width);
        fail_count++;
      end else begin
        oldest_beat = predicted_beats.pop_front();
        beats_checked++;
        if (out_ch.packed_byte !== oldest_beat.packed_byte) begin
          $error("packed_byte: expected %02h, actual %02h",
                 oldest_beat.packed_byte, out_ch.packed_byte);
          fail_count++;
        end
        if (out_ch.is_last !== oldest_beat.is_last) begin
          $error("is_last: expected %0d, actual %0d", oldest_beat.is_last, out_ch.is_last);
          fail_count++;
        end
        if (out_ch.code_width !== oldest_beat.code_width) begin
          $error("code_width: expected %0d, actual %0d",
                 oldest_beat.code_width, out_ch.code_width);
          fail_count++;
        end
      end
    end
  end

  // watchdog: too long with no beat on either side ends the run
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // hand-picked walk through the corner cases
  task automatic test_directed();
    send_item(fwdp_pkg::OP_FLUSH,  8'h00);   // flush with nothing pending
    send_item(fwdp_pkg::OP_ENCODE, 8'h3C);   // encode on an empty table
    send_item(fwdp_pkg::OP_LEARN,  8'h00);   // nul byte is a legal symbol
    send_item(fwdp_pkg::OP_LEARN,  8'h00);   // known byte, ignored
    send_item(fwdp_pkg::OP_ENCODE, 8'h00);   // single entry still uses one bit
    send_item(fwdp_pkg::OP_ENCODE, 8'h7E);   // unknown byte
    send_item(fwdp_pkg::OP_LEARN,  8'hFF);
    send_item(fwdp_pkg::OP_ENCODE, 8'hFF);
    send_item(fwdp_pkg::OP_LEARN,  8'h80);   // width grows to 2
    send_item(fwdp_pkg::OP_LEARN,  8'h01);
    send_item(fwdp_pkg::OP_ENCODE, 8'h01);
    send_item(fwdp_pkg::OP_ENCODE, 8'h80);
    send_item(fwdp_pkg::OP_ENCODE, 8'hFF);   // completes a byte
    send_item(fwdp_pkg::OP_LEARN,  8'h55);   // width 3
    send_item(fwdp_pkg::OP_ENCODE, 8'h55);
    send_item(fwdp_pkg::OP_FLUSH,  8'hFF);   // padded last byte
    send_item(fwdp_pkg::OP_FLUSH,  8'h00);   // second flush has nothing left
    send_item(fwdp_pkg::OP_ENCODE, 8'h00);
    send_item(fwdp_pkg::OP_CLEAR,  8'hA5);   // bits stay pending across a clear
    send_item(fwdp_pkg::OP_ENCODE, 8'h00);   // table now empty
    send_item(fwdp_pkg::OP_FLUSH,  8'h00);   // flush width on an empty table
    send_item(fwdp_pkg::OP_LEARN,  8'h7F);
    send_item(fwdp_pkg::OP_ENCODE, 8'h7F);
    send_item(fwdp_pkg::OP_FLUSH,  8'h00);
  endtask

  // fill all 256 entries, learn into a full table, search to the far end
  task automatic test_full_table();
    send_item(fwdp_pkg::OP_CLEAR, 8'h00);
    for (int k = 0; k < fwdp_pkg::TABLE_DEPTH; k++) begin
      // odd stride: a permutation
      send_item(fwdp_pkg::OP_LEARN, 8'((k * 167 + 13) & 8'hFF));
    end
    send_item(fwdp_pkg::OP_LEARN,  8'($urandom_range(0, 255)));    // table full
    // longest search
    send_item(fwdp_pkg::OP_ENCODE, dict[8'(fwdp_pkg::TABLE_DEPTH - 1)]);
    send_item(fwdp_pkg::OP_ENCODE, dict[8'd0]);
    repeat (6) send_item(fwdp_pkg::OP_ENCODE, 8'($urandom_range(0, 255)));
    send_item(fwdp_pkg::OP_ENCODE, 8'hAB);
    send_item(fwdp_pkg::OP_FLUSH,  8'h00);
    send_item(fwdp_pkg::OP_CLEAR,  8'hFF);
  endtask

  // receiver holds off while the sender keeps going
  task automatic test_backpressure();
    idle_on = 1'b0;
    send_item(fwdp_pkg::OP_FLUSH, 8'h00);
    send_item(fwdp_pkg::OP_CLEAR, 8'h00);
    repeat (3) send_item(fwdp_pkg::OP_LEARN, 8'($urandom_range(0, 255)));
    hold_cycles = HOLD_OFF;
    repeat (40) begin
      send_item(fwdp_pkg::OP_ENCODE, dict[8'($urandom_range(0, int'(dict_count) - 1))]);
    end
    send_item(fwdp_pkg::OP_FLUSH, 8'h00);
    idle_on = 1'b1;
  endtask

  // mostly well-formed sessions (clear, learn, encode, flush), some noise
  task automatic test_random_sessions(input int n_items, input bit with_idle);
    int target;
    int n_learn;
    logic [7:0] sym;
    target = items_sent + n_items;
    while (items_sent < target) begin
      // stretches without idling in between idle stretches
      idle_on = with_idle && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 8)) begin
          send_item(fwdp_pkg::op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
      end else begin
        if ($urandom_range(0, 4) != 0) begin
          send_item(fwdp_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
        end
        // small tables keep the searches short, a few big ones for wide codes
        if (big_tables < 3 && $urandom_range(0, 39) == 0) begin
          n_learn = $urandom_range(100, 256);
          big_tables++;
        end else begin
          n_learn = $urandom_range(1, 12);
        end
        repeat (n_learn) send_item(fwdp_pkg::OP_LEARN, 8'($urandom_range(0, 255)));
        repeat ($urandom_range(4, 40)) begin
          if (dict_count != 0 && $urandom_range(0, 6) != 0) begin
            sym = dict[8'($urandom_range(0, int'(dict_count) - 1))];
          end else begin
            sym = 8'($urandom_range(0, 255));
          end
          send_item(fwdp_pkg::OP_ENCODE, sym);
        end
        // leaving out the flush lets the bit stream run into the next session
        if ($urandom_range(0, 9) != 0) begin
          send_item(fwdp_pkg::OP_FLUSH, 8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    int waited;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = fwdp_pkg::OP_LEARN;
    in_ch.symbol    = 8'h00;
    idle_on         = 1'b1;
    hold_cycles     = 0;
    fail_count      = 0;
    beats_checked   = 0;
    items_sent      = 0;
    big_tables      = 0;
    quiet_cycles    = 0;
    for (int i = 0; i < 4; i++) op_seen[2'(i)] = 0;
    for (int i = 0; i < fwdp_pkg::TABLE_DEPTH; i++) dict[8'(i)] = '0;
    dict_count = '0;
    pend_bits  = '0;
    pend_fill  = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_full_table();
    test_backpressure();
    test_random_sessions(480, 1'b1);
    // last part runs with both sides always ready
    idle_on = 1'b0;
    test_random_sessions(80, 1'b0);

    @(negedge clk);
    in_ch.valid <= 1'b0;

    waited = 0;
    while (predicted_beats.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (predicted_beats.size() != 0) begin
      $error("%0d predicted beats never arrived", predicted_beats.size());
      fail_count++;
    end
    // catch any stray beat still on its way
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d items: %0d learn, %0d encode, %0d flush, %0d clear",
             items_sent, op_seen[fwdp_pkg::OP_LEARN], op_seen[fwdp_pkg::OP_ENCODE],
             op_seen[fwdp_pkg::OP_FLUSH], op_seen[fwdp_pkg::OP_CLEAR]);
    $display("checked %0d packed beats, %0d mismatches", beats_checked, fail_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/fwdp_pkg.sv
rtl/core/fwdp_if.sv
rtl/core/fwdp_search.sv
rtl/core/fwdp_packer.sv
rtl/core/fixed_width_dictionary_packer.sv
tb/fixed_width_dictionary_packer_tb.sv
